@@ rtl/mep_pkg.sv @@
// mep_pkg: shared types and constants of the mandelbrot escape pixel unit
// used by the controller, the orbit datapath, the shade datapath and the top level
package mep_pkg;

  // fixed-point layout of coordinates: signed Q4.28
  localparam int FracBits = 28;
  localparam int CfgW     = 32;
  localparam int ColW     = 12;
  localparam int ZW       = 31;  // z and c once the far test has passed (|x| < 4.0)
  localparam int ProdW    = 45;  // column * step
  localparam int SqW      = 34;  // floor-shifted product of two z parts
  localparam int SumW     = 36;  // new z before the magnitude test

  // iteration limit, must be a power of two up to 65536
  localparam int MaxIterations = 256;
  localparam int CountW        = $clog2(MaxIterations + 1);
  localparam int TShift        = 16 - $clog2(MaxIterations);
  localparam int TW            = 17;  // Q0.16 with one integer bit
  localparam int ColorW        = 8;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegLeftReal  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBottomImag = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStepReal  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStepImag  = 2'd3;

  localparam logic signed [CfgW-1:0] LeftRealRst  = -32'sd536870912;
  localparam logic signed [CfgW-1:0] BottomImagRst = -32'sd536870912;
  localparam logic signed [CfgW-1:0] StepRealRst  = 32'sd262144;
  localparam logic signed [CfgW-1:0] StepImagRst  = 32'sd262144;

  typedef enum logic [2:0] {
    StIdle,
    StOrigin,
    StSquare,
    StUpdate,
    StShade1,
    StShade2,
    StShade3,
    StShade4
  } mep_state_e;

  typedef struct packed {
    logic load;
    logic origin;
    logic square;
    logic update;
    logic shade1;
    logic shade2;
    logic shade3;
    logic shade4;
  } mep_cmd_t;

  typedef struct packed {
    logic far;
    logic orbit_done;
  } mep_stat_t;

endpackage

@@ rtl/mep_ctrl.sv @@
// mep_ctrl: sequencer of the mandelbrot escape pixel unit
// drives the orbit and shade datapaths, depends on mep_pkg
module mep_ctrl
  import mep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  mep_stat_t stat_i,
  output mep_cmd_t  cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  mep_state_e state_q, state_d;
  logic       done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StShade4);
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StOrigin;
        end
      end
      StOrigin: begin
        cmd_o.origin = 1'b1;
        state_d      = stat_i.far ? StShade1 : StSquare;
      end
      StSquare: begin
        cmd_o.square = 1'b1;
        state_d      = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = stat_i.orbit_done ? StShade1 : StSquare;
      end
      StShade1: begin
        cmd_o.shade1 = 1'b1;
        state_d      = StShade2;
      end
      StShade2: begin
        cmd_o.shade2 = 1'b1;
        state_d      = StShade3;
      end
      StShade3: begin
        cmd_o.shade3 = 1'b1;
        state_d      = StShade4;
      end
      StShade4: begin
        cmd_o.shade4 = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

endmodule

@@ rtl/mep_orbit.sv @@
// mep_orbit: configuration registers, point mapping and z = z^2 + c iteration
// depends on mep_pkg, driven by mep_ctrl
module mep_orbit
  import mep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [ColW-1:0]    column_i,
  input  logic [ColW-1:0]    row_i,
  input  mep_cmd_t           cmd_i,
  output mep_stat_t          stat_o,
  output logic [CountW-1:0]  count_o,
  output logic               escaped_o
);

  localparam logic signed [ProdW:0]  FarLimit = 46'sd1073741824;  // 4.0
  localparam logic signed [SumW-1:0] ZTwo     = 36'sd536870912;   // 2.0
  localparam logic signed [SumW-1:0] ZFour    = 36'sd1073741824;  // 4.0

  logic signed [CfgW-1:0]  left_real_q, bottom_imag_q, step_real_q, step_imag_q;
  logic signed [ProdW-1:0] prod_r_q, prod_i_q;
  logic signed [ZW-1:0]    c_r_q, c_i_q, z_r_q, z_i_q;
  logic signed [SqW-1:0]   sq_rr_q, sq_ii_q, sq_ri_q;
  logic [CountW-1:0]       count_q;
  logic                    esc_q;

  logic signed [ProdW:0]    c_r_full, c_i_full;
  logic                     far;
  logic signed [2*ZW-1:0]   p_rr, p_ii, p_ri;
  logic signed [SumW-1:0]   new_r, new_i, sq_sum;
  logic                     big, sq_esc, limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_real_q   <= LeftRealRst;
      bottom_imag_q <= BottomImagRst;
      step_real_q   <= StepRealRst;
      step_imag_q   <= StepImagRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLeftReal:   left_real_q   <= cfg_wdata_i;
        RegBottomImag: bottom_imag_q <= cfg_wdata_i;
        RegStepReal:   step_real_q   <= cfg_wdata_i;
        RegStepImag:   step_imag_q   <= cfg_wdata_i;
        default:       left_real_q   <= left_real_q;
      endcase
    end
  end

  // point mapping: the multiply is registered, the add and far test follow
  assign c_r_full = (ProdW + 1)'(left_real_q) + (ProdW + 1)'(prod_r_q);
  assign c_i_full = (ProdW + 1)'(bottom_imag_q) + (ProdW + 1)'(prod_i_q);
  assign far = (c_r_full >= FarLimit) || (c_r_full <= -FarLimit) ||
               (c_i_full >= FarLimit) || (c_i_full <= -FarLimit);

  // arithmetic shift of the full product gives the floor
  assign p_rr = (2 * ZW)'(z_r_q) * (2 * ZW)'(z_r_q);
  assign p_ii = (2 * ZW)'(z_i_q) * (2 * ZW)'(z_i_q);
  assign p_ri = (2 * ZW)'(z_r_q) * (2 * ZW)'(z_i_q);

  assign new_r  = SumW'(sq_rr_q) - SumW'(sq_ii_q) + SumW'(c_r_q);
  assign new_i  = (SumW'(sq_ri_q) <<< 1) + SumW'(c_i_q);
  assign big    = (new_r >= ZTwo) || (new_r <= -ZTwo) || (new_i >= ZTwo) || (new_i <= -ZTwo);
  // squares of the z left by the previous pass, none before the first pass
  assign sq_sum = SumW'(sq_rr_q) + SumW'(sq_ii_q);
  assign sq_esc = (count_q != '0) && (sq_sum >= ZFour);
  assign limit  = (count_q == CountW'(MaxIterations));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prod_r_q <= ProdW'($signed({1'b0, column_i})) * ProdW'(step_real_q);
      prod_i_q <= ProdW'($signed({1'b0, row_i})) * ProdW'(step_imag_q);
    end
    if (cmd_i.origin) begin
      c_r_q <= c_r_full[ZW-1:0];
      c_i_q <= c_i_full[ZW-1:0];
      z_r_q <= c_r_full[ZW-1:0];
      z_i_q <= c_i_full[ZW-1:0];
    end
    if (cmd_i.square) begin
      sq_rr_q <= $signed(p_rr[2*ZW-1:FracBits]);
      sq_ii_q <= $signed(p_ii[2*ZW-1:FracBits]);
      sq_ri_q <= $signed(p_ri[2*ZW-1:FracBits]);
    end
    if (cmd_i.update) begin
      z_r_q <= new_r[ZW-1:0];
      z_i_q <= new_i[ZW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      esc_q   <= 1'b0;
    end else if (cmd_i.load) begin
      count_q <= '0;
      esc_q   <= 1'b0;
    end else if (cmd_i.origin && far) begin
      count_q <= CountW'(1);
      esc_q   <= 1'b1;
    end else if (cmd_i.update) begin
      if (!sq_esc && !limit) begin
        count_q <= count_q + CountW'(1);
      end
      esc_q <= sq_esc || (!limit && big);
    end
  end

  assign stat_o.far        = far;
  assign stat_o.orbit_done = sq_esc || limit || big;
  assign count_o           = count_q;
  assign escaped_o         = esc_q;

endmodule

@@ rtl/mep_shade.sv @@
// mep_shade: four-step color polynomial datapath and result registers
// depends on mep_pkg, driven by mep_ctrl
module mep_shade
  import mep_pkg::*;
(
  input  logic              clk_i,
  input  mep_cmd_t          cmd_i,
  input  logic [CountW-1:0] count_i,
  input  logic              escaped_i,
  output logic [CountW-1:0] iter_count_o,
  output logic              escaped_o,
  output logic [ColorW-1:0] red_o,
  output logic [ColorW-1:0] green_o,
  output logic [ColorW-1:0] blue_o
);

  localparam logic [TW-1:0] OneT = 17'h10000;

  // product of two Q0.16 values up to 1.0, result up to 1.0
  function automatic logic [TW-1:0] mulq(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [2*TW-1:0] p;
    p = (2 * TW)'(a) * (2 * TW)'(b);
    return p[TW+15:16];
  endfunction

  logic [TW-1:0] t_w, u_w;
  logic [TW-1:0] t_q, u_q, tt_q, uu_q, rb_q, gc_q, bb_q, rc_q, bc_q;
  logic [ColorW-1:0] g_q;
  logic [28:0]   red_p, blue_p, green_p;

  assign t_w = TW'(count_i) << TShift;
  assign u_w = OneT - t_w;

  assign green_p = 29'(gc_q) * 29'd3825;
  assign red_p   = 29'(rc_q) * 29'd2295;
  assign blue_p  = 29'(bc_q) * 29'd4335;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shade1) begin
      t_q  <= t_w;
      u_q  <= u_w;
      tt_q <= mulq(t_w, t_w);
      uu_q <= mulq(u_w, u_w);
    end
    if (cmd_i.shade2) begin
      rb_q <= mulq(tt_q, t_q);
      gc_q <= mulq(uu_q, tt_q);
      bb_q <= mulq(uu_q, u_q);
    end
    if (cmd_i.shade3) begin
      rc_q <= mulq(rb_q, u_q);
      bc_q <= mulq(bb_q, t_q);
      g_q  <= green_p[23:16];
    end
    if (cmd_i.shade4) begin
      iter_count_o <= count_i;
      escaped_o    <= escaped_i;
      red_o        <= red_p[23:16];
      green_o      <= g_q;
      blue_o       <= blue_p[24:17];
    end
  end

endmodule

@@ rtl/mandelbrot_escape_pixel_unit.sv @@
// Mandelbrot escape-time pixel unit. A pixel is taken when start_i is high and busy_o is low;
// its column and row map to c = left + column*step_real, bottom + row*step_imag (Q4.28), and
// z = z^2 + c is iterated until |z|^2 >= 4 or 256 passes. Each pass runs through the
// square-and-update loop (a three-multiplier square stage, then the add and escape tests);
// a pixel ends when a part of z leaves the +-2 box or when the squared magnitude test or the
// limit ends it, and a point with a part beyond +-4 skips the loop. The result appears on the
// result ports for one cycle with done_o and must be taken then; the outputs hold until the
// next result. The next pixel may start in the cycle done_o is shown. Configuration writes
// through cfg_we_i take effect at once and belong to idle time.
module mandelbrot_escape_pixel_unit
  import mep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [ColW-1:0]    column_i,
  input  logic [ColW-1:0]    row_i,
  output logic               done_o,
  output logic [CountW-1:0]  iter_count_o,
  output logic               escaped_o,
  output logic [ColorW-1:0]  red_o,
  output logic [ColorW-1:0]  green_o,
  output logic [ColorW-1:0]  blue_o
);

  mep_cmd_t          cmd;
  mep_stat_t         stat;
  logic [CountW-1:0] count;
  logic              esc;

  mep_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  mep_orbit u_orbit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .count_o     (count),
    .escaped_o   (esc)
  );

  mep_shade u_shade (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .count_i      (count),
    .escaped_i    (esc),
    .iter_count_o (iter_count_o),
    .escaped_o    (escaped_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("unit not busy after a start transfer");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while unit still busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !escaped_o) |-> (iter_count_o == CountW'(MaxIterations)))
    else $error("non-escaped result below the iteration limit");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (iter_count_o != '0))
    else $error("result with zero passes");
`endif

endmodule

@@ verif/tb_mandelbrot_escape_pixel_unit.sv @@
// tb_mandelbrot_escape_pixel_unit: self-checking testbench of the escape-time pixel unit
// drives pixels through the start/busy port, predicts count, escape flag and color per pixel
// depends on mep_pkg and mandelbrot_escape_pixel_unit
`timescale 1ns / 100ps

module tb_mandelbrot_escape_pixel_unit;
  import mep_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int          PhaseItems = 250;
  localparam int          RandPhases = 7;

  typedef struct {
    logic [ColW-1:0] column;
    logic [ColW-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [CountW-1:0] iter_count;
    logic              escaped;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } shade_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               start_i;
  logic               busy_o;
  logic [ColW-1:0]    column_i;
  logic [ColW-1:0]    row_i;
  logic               done_o;
  logic [CountW-1:0]  iter_count_o;
  logic               escaped_o;
  logic [ColorW-1:0]  red_o;
  logic [ColorW-1:0]  green_o;
  logic [ColorW-1:0]  blue_o;

  mandelbrot_escape_pixel_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .column_i     (column_i),
    .row_i        (row_i),
    .done_o       (done_o),
    .iter_count_o (iter_count_o),
    .escaped_o    (escaped_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  // view registers as the unit should hold them
  logic signed [CfgW-1:0] view_left;
  logic signed [CfgW-1:0] view_bottom;
  logic signed [CfgW-1:0] view_step_re;
  logic signed [CfgW-1:0] view_step_im;

  pixel_t      pending_pixels[$];
  shade_t      shade_q[$];
  int          idle_pct;
  int unsigned cycle_cnt;
  int          fail_cnt;
  int          pixel_cnt;
  int          escaped_cnt;
  int          bounded_cnt;
  int          view_cnt;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic longint fix_mul(longint a, longint b);
    // arithmetic shift floors toward minus infinity
    return (a * b) >>> FracBits;
  endfunction

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic shade_t escape_time(logic [ColW-1:0] col, logic [ColW-1:0] row);
    longint      cr, ci, zr, zi, nr, ni, two, four;
    longint      t, u, a, b, c;
    int unsigned count;
    logic        esc;
    shade_t      res;
    two   = longint'(2) <<< FracBits;
    four  = longint'(4) <<< FracBits;
    cr    = longint'(view_left) + longint'(col) * longint'(view_step_re);
    ci    = longint'(view_bottom) + longint'(row) * longint'(view_step_im);
    count = 0;
    esc   = 1'b0;
    if (mag_of(cr) >= four || mag_of(ci) >= four) begin
      count = 1;
      esc   = 1'b1;
    end else begin
      zr = cr;
      zi = ci;
      while (count < MaxIterations && !esc) begin
        nr = fix_mul(zr, zr) - fix_mul(zi, zi) + cr;
        ni = 2 * fix_mul(zr, zi) + ci;
        count++;
        zr = nr;
        zi = ni;
        if (mag_of(zr) >= two || mag_of(zi) >= two) begin
          esc = 1'b1;
        end else if (fix_mul(zr, zr) + fix_mul(zi, zi) >= four) begin
          esc = 1'b1;
        end
      end
    end
    t = (longint'(count) << 16) / MaxIterations;
    if (t > 65536) t = 65536;
    u = 65536 - t;
    a = (t * t) >> 16;
    b = (a * t) >> 16;
    c = (b * u) >> 16;
    res.red = ColorW'((2295 * c) >> 16);
    a = (u * u) >> 16;
    b = (t * t) >> 16;
    c = (a * b) >> 16;
    res.green = ColorW'((3825 * c) >> 16);
    a = (u * u) >> 16;
    b = (a * u) >> 16;
    c = (b * t) >> 16;
    res.blue       = ColorW'((4335 * c) >> 17);
    res.iter_count = CountW'(count);
    res.escaped    = esc;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    fail_cnt++;
    if (fail_cnt <= 40) begin
      $display("mismatch on pixel %0d: %s got %0d want %0d", pixel_cnt, what, got, want);
    end
  endtask

  // driver: start may drop while busy so gaps land anywhere in the pixel's work
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      shade_q.push_back(escape_time(column_i, row_i));
      void'(pending_pixels.pop_front());
    end
    if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start_i  <= 1'b1;
      column_i <= pending_pixels[0].column;
      row_i    <= pending_pixels[0].row;
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor: every done strobe is one result transfer
  always @(posedge clk_i) begin
    shade_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (shade_q.size() == 0) begin
        report_mismatch("result without pixel, iter_count", iter_count_o, 0);
      end else begin
        want = shade_q.pop_front();
        if (iter_count_o !== want.iter_count)
          report_mismatch("iter_count", iter_count_o, want.iter_count);
        if (escaped_o !== want.escaped) report_mismatch("escaped", escaped_o, want.escaped);
        if (red_o !== want.red) report_mismatch("red", red_o, want.red);
        if (green_o !== want.green) report_mismatch("green", green_o, want.green);
        if (blue_o !== want.blue) report_mismatch("blue", blue_o, want.blue);
        if (want.escaped) escaped_cnt++;
        else bounded_cnt++;
      end
      pixel_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[mandelbrot_escape_pixel_unit] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegLeftReal:   view_left    = val;
      RegBottomImag: view_bottom  = val;
      RegStepReal:   view_step_re = val;
      RegStepImag:   view_step_im = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_view(logic [CfgW-1:0] left, logic [CfgW-1:0] bottom,
                          logic [CfgW-1:0] step_re, logic [CfgW-1:0] step_im);
    write_reg(RegLeftReal, left);
    write_reg(RegBottomImag, bottom);
    write_reg(RegStepReal, step_re);
    write_reg(RegStepImag, step_im);
    cfg_we_i <= 1'b0;
    view_cnt++;
  endtask

  task automatic queue_pixel(int unsigned col, int unsigned row);
    pixel_t p;
    p.column = ColW'(col);
    p.row    = ColW'(row);
    pending_pixels.push_back(p);
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || start_i || shade_q.size() != 0) @(posedge clk_i);
  endtask

  // mostly a window around the set sized to the columns in use, now and then raw words
  task automatic random_view(output int col_bits);
    int span, center_re, center_im, step;
    if ($urandom_range(5) == 0) begin
      col_bits = ColW;
      set_view($urandom, $urandom, $urandom, $urandom);
    end else begin
      col_bits  = $urandom_range(ColW, 5);
      span      = int'($urandom_range(3 << 28, 1 << 25));
      center_re = int'($urandom_range(5 << 27, 0)) - (1 << 29);
      center_im = int'($urandom_range(5 << 27, 0)) - (5 << 26);
      step      = span >>> col_bits;
      if ($urandom_range(3) == 0) begin
        set_view(center_re + span / 2, center_im + span / 2, -step, -step);
      end else begin
        set_view(center_re - span / 2, center_im - span / 2, step, step);
      end
    end
  endtask

  initial begin
    int col_bits;
    int lim;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegLeftReal;
    cfg_wdata_i  = '0;
    start_i      = 1'b0;
    column_i     = '0;
    row_i        = '0;
    idle_pct     = 0;
    cycle_cnt    = 0;
    fail_cnt     = 0;
    pixel_cnt    = 0;
    escaped_cnt  = 0;
    bounded_cnt  = 0;
    view_cnt     = 1;
    view_left    = LeftRealRst;
    view_bottom  = BottomImagRst;
    view_step_re = StepRealRst;
    view_step_im = StepImagRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset view: corners, origin (runs to the limit), period two, preperiodic, real axis points and the end at -2
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(2048, 2048);
    queue_pixel(1024, 2048);
    queue_pixel(2048, 3072);
    queue_pixel(1536, 2048);
    queue_pixel(2560, 2048);
    queue_pixel(0, 2048);
    wait_idle();

    // extreme register words: far points at the corners, pixel (1,1) lands next to the origin
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(1, 1);
    wait_idle();
    // exactly 4.0 on the real part is far, one lsb below is not
    set_view(32'h4000_0000, '0, '0, '0);
    queue_pixel(5, 5);
    wait_idle();
    set_view(32'h3FFF_FFFF, 32'hC000_0001, '0, '0);
    queue_pixel(0, 0);
    wait_idle();
    // both parts stay inside the box but the squared magnitude reaches four
    set_view(-32'sd510027366, 32'sd134217728, '0, '0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    wait_idle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      random_view(col_bits);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 71;
        default: idle_pct = 8;
      endcase
      lim = (1 << col_bits) - 1;
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(9) == 0) queue_pixel($urandom_range(4095), $urandom_range(4095));
        else queue_pixel($urandom_range(lim), $urandom_range(lim));
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    $display("checked %0d pixels under %0d view settings", pixel_cnt, view_cnt);
    $display("%0d escaped, %0d stayed bounded to the limit", escaped_cnt, bounded_cnt);
    if (fail_cnt == 0) begin
      $display("[mandelbrot_escape_pixel_unit] OK");
    end else begin
      $display("[mandelbrot_escape_pixel_unit] ERROR");
    end
    $finish;
  end

endmodule
